FILE: hw/rtl/qcoc_pkg.sv
// ----------------------------------------------------------------------------
// qcoc_pkg
// Shared types and constants for the quadrilateral corner ordering block.
// ----------------------------------------------------------------------------
package qcoc_pkg;

    localparam int COORD_W        = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int QBITS          = 26;
    localparam int DEN_W          = 34;
    localparam int REM_W          = 51;
    localparam int CMP_W          = DEN_W + QBITS;
    localparam int CEN_W          = 24;

    localparam logic signed [CEN_W-1:0] CEN_MAX = 24'sh7FFFFF;
    localparam logic signed [CEN_W-1:0] CEN_MIN = -24'sh800000;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic signed [CEN_W-1:0] center_t;

    typedef struct packed {
        coord_t corner0_x;
        coord_t corner0_y;
        coord_t corner1_x;
        coord_t corner1_y;
        coord_t corner2_x;
        coord_t corner2_y;
        coord_t corner3_x;
        coord_t corner3_y;
    } quad_in_t;

    typedef struct packed {
        coord_t  top_left_x;
        coord_t  top_left_y;
        coord_t  top_right_x;
        coord_t  top_right_y;
        coord_t  bottom_right_x;
        coord_t  bottom_right_y;
        coord_t  bottom_left_x;
        coord_t  bottom_left_y;
        center_t center_x;
        center_t center_y;
        logic    diagonals_parallel;
        logic    center_saturated;
    } quad_out_t;

    typedef struct packed {
        coord_t tl_x;
        coord_t tl_y;
        coord_t tr_x;
        coord_t tr_y;
        coord_t br_x;
        coord_t br_y;
        coord_t bl_x;
        coord_t bl_y;
    } pts_t;

    typedef struct packed {
        pts_t             pts;
        logic             par;
        logic [DEN_W-1:0] den;
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [QBITS-1:0] q_x;
        logic [QBITS-1:0] q_y;
        logic             cap_x;
        logic             cap_y;
        logic             nneg_x;
        logic             nneg_y;
    } div_lane_t;

endpackage

FILE: hw/rtl/qcoc_order.sv
// ----------------------------------------------------------------------------
// qcoc_order
// Five-stage pipeline that finds the extreme corners by coordinate sum and
// splits the remaining two by the sign of a cross product.
// ----------------------------------------------------------------------------
module qcoc_order
    import qcoc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  quad_in_t in_data,
    output logic     up_ready,
    output logic     out_valid,
    output pts_t     out_data,
    input  logic     down_ready
);

    localparam int NST = 5;
    localparam coord_t CMASK = (COORD_BITS >= COORD_W) ? '1
                                                      : coord_t'((1 << COORD_BITS) - 1);

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    always_comb
    begin
        rdy[NST] = down_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
                end
            end
        end
    end

    assign up_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];

    coord_t        px_next [4];
    coord_t        py_next [4];
    coord_t        px1_reg [4];
    coord_t        py1_reg [4];
    logic [16:0]   s1_reg  [4];

    always_comb
    begin
        px_next[0] = in_data.corner0_x & CMASK;
        py_next[0] = in_data.corner0_y & CMASK;
        px_next[1] = in_data.corner1_x & CMASK;
        py_next[1] = in_data.corner1_y & CMASK;
        px_next[2] = in_data.corner2_x & CMASK;
        py_next[2] = in_data.corner2_y & CMASK;
        px_next[3] = in_data.corner3_x & CMASK;
        py_next[3] = in_data.corner3_y & CMASK;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int i = 0; i < 4; i++)
            begin
                px1_reg[i] <= px_next[i];
                py1_reg[i] <= py_next[i];
                s1_reg[i]  <= {1'b0, px_next[i]} + {1'b0, py_next[i]};
            end
        end
    end

    logic [1:0] tl_next, br_next, o0_next, o1_next, cnt;
    coord_t     px2_reg [4];
    coord_t     py2_reg [4];
    logic [1:0] tl2_reg, br2_reg, o02_reg, o12_reg;

    always_comb
    begin
        tl_next = '0;
        br_next = '0;
        for (int i = 1; i < 4; i++)
        begin
            if (s1_reg[i] < s1_reg[tl_next])
            begin
                tl_next = 2'(i);
            end
            if (s1_reg[i] > s1_reg[br_next])
            begin
                br_next = 2'(i);
            end
        end
        o0_next = '0;
        o1_next = '0;
        cnt     = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (2'(i) != tl_next && 2'(i) != br_next && cnt < 2'd2)
            begin
                if (cnt == 2'd0)
                begin
                    o0_next = 2'(i);
                end
                else
                begin
                    o1_next = 2'(i);
                end
                cnt = cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            tl2_reg <= tl_next;
            br2_reg <= br_next;
            o02_reg <= o0_next;
            o12_reg <= o1_next;
        end
    end

    coord_t tlx3_reg, tly3_reg, o0x3_reg, o0y3_reg, o1x3_reg, o1y3_reg, brx3_reg, bry3_reg;
    logic signed [16:0] d1x3_reg, d0y3_reg, d1y3_reg, d0x3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            tlx3_reg <= px2_reg[tl2_reg];
            tly3_reg <= py2_reg[tl2_reg];
            o0x3_reg <= px2_reg[o02_reg];
            o0y3_reg <= py2_reg[o02_reg];
            o1x3_reg <= px2_reg[o12_reg];
            o1y3_reg <= py2_reg[o12_reg];
            brx3_reg <= px2_reg[br2_reg];
            bry3_reg <= py2_reg[br2_reg];
            d1x3_reg <= $signed({1'b0, px2_reg[o12_reg]}) - $signed({1'b0, px2_reg[tl2_reg]});
            d0y3_reg <= $signed({1'b0, py2_reg[o02_reg]}) - $signed({1'b0, py2_reg[tl2_reg]});
            d1y3_reg <= $signed({1'b0, py2_reg[o12_reg]}) - $signed({1'b0, py2_reg[tl2_reg]});
            d0x3_reg <= $signed({1'b0, px2_reg[o02_reg]}) - $signed({1'b0, px2_reg[tl2_reg]});
        end
    end

    coord_t tlx4_reg, tly4_reg, o0x4_reg, o0y4_reg, o1x4_reg, o1y4_reg, brx4_reg, bry4_reg;
    logic signed [33:0] za4_reg, zb4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            tlx4_reg <= tlx3_reg;
            tly4_reg <= tly3_reg;
            o0x4_reg <= o0x3_reg;
            o0y4_reg <= o0y3_reg;
            o1x4_reg <= o1x3_reg;
            o1y4_reg <= o1y3_reg;
            brx4_reg <= brx3_reg;
            bry4_reg <= bry3_reg;
            za4_reg  <= d1x3_reg * d0y3_reg;
            zb4_reg  <= d1y3_reg * d0x3_reg;
        end
    end

    logic signed [34:0] z;
    pts_t               pts_next;
    pts_t               pts5_reg;

    always_comb
    begin
        z = 35'(za4_reg) - 35'(zb4_reg);
        pts_next.tl_x = tlx4_reg;
        pts_next.tl_y = tly4_reg;
        pts_next.br_x = brx4_reg;
        pts_next.br_y = bry4_reg;
        if (z < 0)
        begin
            pts_next.tr_x = o0x4_reg;
            pts_next.tr_y = o0y4_reg;
            pts_next.bl_x = o1x4_reg;
            pts_next.bl_y = o1y4_reg;
        end
        else
        begin
            pts_next.tr_x = o1x4_reg;
            pts_next.tr_y = o1y4_reg;
            pts_next.bl_x = o0x4_reg;
            pts_next.bl_y = o0y4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            pts5_reg <= pts_next;
        end
    end

    assign out_data = pts5_reg;

endmodule

FILE: hw/rtl/qcoc_solve.sv
// ----------------------------------------------------------------------------
// qcoc_solve
// Nine-stage pipeline that sets up the diagonal line equations and forms the
// rounded numerators and the denominator for the quotient pipeline.
// ----------------------------------------------------------------------------
module qcoc_solve
    import qcoc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  pts_t      in_data,
    output logic      up_ready,
    output logic      out_valid,
    output div_lane_t out_data,
    input  logic      down_ready
);

    localparam int NST = 9;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    always_comb
    begin
        rdy[NST] = down_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
                end
            end
        end
    end

    assign up_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];

    pts_t pts_reg [NST-1];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST - 1; i++)
        begin
            if (rdy[i])
            begin
                pts_reg[i] <= (i == 0) ? in_data : pts_reg[i-1];
            end
        end
    end

    logic signed [16:0] fx1_reg, fy1_reg, ex1_reg, ey1_reg, gx1_reg, gy1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            fx1_reg <= $signed({1'b0, in_data.tr_x}) - $signed({1'b0, in_data.bl_x});
            fy1_reg <= $signed({1'b0, in_data.tr_y}) - $signed({1'b0, in_data.bl_y});
            ex1_reg <= $signed({1'b0, in_data.br_x}) - $signed({1'b0, in_data.tl_x});
            ey1_reg <= $signed({1'b0, in_data.br_y}) - $signed({1'b0, in_data.tl_y});
            gx1_reg <= $signed({1'b0, in_data.tl_x}) - $signed({1'b0, in_data.bl_x});
            gy1_reg <= $signed({1'b0, in_data.tl_y}) - $signed({1'b0, in_data.bl_y});
        end
    end

    logic signed [33:0] pa2_reg, pb2_reg, pc2_reg, pd2_reg;
    logic signed [16:0] fx2_reg, fy2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            pa2_reg <= fx1_reg * ey1_reg;
            pb2_reg <= fy1_reg * ex1_reg;
            pc2_reg <= gx1_reg * ey1_reg;
            pd2_reg <= gy1_reg * ex1_reg;
            fx2_reg <= fx1_reg;
            fy2_reg <= fy1_reg;
        end
    end

    logic signed [33:0] dc3_reg, nc3_reg;
    logic signed [16:0] fx3_reg, fy3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            dc3_reg <= pa2_reg - pb2_reg;
            nc3_reg <= pc2_reg - pd2_reg;
            fx3_reg <= fx2_reg;
            fy3_reg <= fy2_reg;
        end
    end

    logic signed [33:0] dabs_next, ncs_next;
    logic [32:0]        dmag4_reg;
    logic signed [33:0] ncs4_reg;
    logic               par4_reg, fxneg4_reg, fyneg4_reg;
    logic [15:0]        fxmag4_reg, fymag4_reg;

    always_comb
    begin
        dabs_next = dc3_reg[33] ? -dc3_reg : dc3_reg;
        ncs_next  = dc3_reg[33] ? -nc3_reg : nc3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            dmag4_reg  <= dabs_next[32:0];
            ncs4_reg   <= ncs_next;
            par4_reg   <= (dc3_reg == '0);
            fxneg4_reg <= fx3_reg[16];
            fyneg4_reg <= fy3_reg[16];
            fxmag4_reg <= fx3_reg[16] ? 16'(-fx3_reg) : fx3_reg[15:0];
            fymag4_reg <= fy3_reg[16] ? 16'(-fy3_reg) : fy3_reg[15:0];
        end
    end

    logic signed [33:0] ncabs_next;
    logic [32:0]        ncmag5_reg, dmag5_reg;
    logic [15:0]        fxmag5_reg, fymag5_reg;
    logic               negx5_reg, negy5_reg, par5_reg;

    assign ncabs_next = ncs4_reg[33] ? -ncs4_reg : ncs4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            ncmag5_reg <= ncabs_next[32:0];
            dmag5_reg  <= dmag4_reg;
            fxmag5_reg <= fxmag4_reg;
            fymag5_reg <= fymag4_reg;
            par5_reg   <= par4_reg;
            negx5_reg  <= (fxneg4_reg != ncs4_reg[33]) && (fxmag4_reg != '0)
                          && (ncs4_reg != '0);
            negy5_reg  <= (fyneg4_reg != ncs4_reg[33]) && (fymag4_reg != '0)
                          && (ncs4_reg != '0);
        end
    end

    logic [32:0] plx6_reg, ply6_reg;
    logic [31:0] phx6_reg, phy6_reg;
    logic [32:0] dmag6_reg;
    logic        negx6_reg, negy6_reg, par6_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            plx6_reg  <= fxmag5_reg * ncmag5_reg[16:0];
            phx6_reg  <= fxmag5_reg * ncmag5_reg[32:17];
            ply6_reg  <= fymag5_reg * ncmag5_reg[16:0];
            phy6_reg  <= fymag5_reg * ncmag5_reg[32:17];
            dmag6_reg <= dmag5_reg;
            negx6_reg <= negx5_reg;
            negy6_reg <= negy5_reg;
            par6_reg  <= par5_reg;
        end
    end

    logic [48:0] prx_next, pry_next;
    logic [49:0] px7_reg, py7_reg;
    logic [32:0] dmag7_reg;
    logic        negx7_reg, negy7_reg, par7_reg;

    assign prx_next = (49'(phx6_reg) << 17) + 49'(plx6_reg);
    assign pry_next = (49'(phy6_reg) << 17) + 49'(ply6_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            px7_reg   <= {prx_next, 1'b0};
            py7_reg   <= {pry_next, 1'b0};
            dmag7_reg <= dmag6_reg;
            negx7_reg <= negx6_reg;
            negy7_reg <= negy6_reg;
            par7_reg  <= par6_reg;
        end
    end

    logic [REM_W-1:0] sumx, sumy, dpx, dpy, ddx, ddy, mx_next, my_next;
    logic             gtx, gty;
    logic [REM_W-1:0] mx8_reg, my8_reg;
    logic [32:0]      dmag8_reg;
    logic             nnx8_reg, nny8_reg, par8_reg;

    always_comb
    begin
        sumx    = REM_W'(px7_reg) + REM_W'(dmag7_reg);
        sumy    = REM_W'(py7_reg) + REM_W'(dmag7_reg);
        dpx     = REM_W'(px7_reg) - REM_W'(dmag7_reg);
        dpy     = REM_W'(py7_reg) - REM_W'(dmag7_reg);
        ddx     = REM_W'(dmag7_reg) - REM_W'(px7_reg);
        ddy     = REM_W'(dmag7_reg) - REM_W'(py7_reg);
        gtx     = REM_W'(px7_reg) > REM_W'(dmag7_reg);
        gty     = REM_W'(py7_reg) > REM_W'(dmag7_reg);
        mx_next = !negx7_reg ? sumx : (gtx ? dpx : ddx);
        my_next = !negy7_reg ? sumy : (gty ? dpy : ddy);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            mx8_reg   <= mx_next;
            my8_reg   <= my_next;
            dmag8_reg <= dmag7_reg;
            nnx8_reg  <= negx7_reg && gtx;
            nny8_reg  <= negy7_reg && gty;
            par8_reg  <= par7_reg;
        end
    end

    logic [DEN_W-1:0] den_next;
    logic [CMP_W-1:0] lim;
    div_lane_t        lane9_reg;

    assign den_next = {dmag8_reg, 1'b0};
    assign lim      = CMP_W'(den_next) << QBITS;

    always_ff @(posedge clk)
    begin
        if (rdy[8])
        begin
            lane9_reg.pts    <= pts_reg[7];
            lane9_reg.par    <= par8_reg;
            lane9_reg.den    <= den_next;
            lane9_reg.rem_x  <= mx8_reg;
            lane9_reg.rem_y  <= my8_reg;
            lane9_reg.q_x    <= '0;
            lane9_reg.q_y    <= '0;
            lane9_reg.cap_x  <= CMP_W'(mx8_reg) >= lim;
            lane9_reg.cap_y  <= CMP_W'(my8_reg) >= lim;
            lane9_reg.nneg_x <= nnx8_reg;
            lane9_reg.nneg_y <= nny8_reg;
        end
    end

    assign out_data = lane9_reg;

endmodule

FILE: hw/rtl/qcoc_div_stage.sv
// ----------------------------------------------------------------------------
// qcoc_div_stage
// One registered step of the restoring divider: resolves one quotient bit
// for both axes against the shared denominator.
// ----------------------------------------------------------------------------
module qcoc_div_stage
    import qcoc_pkg::*;
#(
    parameter int SHIFT = 0
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  div_lane_t in_data,
    output logic      up_ready,
    output logic      out_valid,
    output div_lane_t out_data,
    input  logic      down_ready
);

    logic             vld_reg;
    logic             rdy;
    logic [CMP_W-1:0] sub;
    logic             gex, gey;
    div_lane_t        lane_next;
    div_lane_t        lane_reg;

    assign rdy = !vld_reg || down_ready;

    always_comb
    begin
        sub       = CMP_W'(in_data.den) << SHIFT;
        gex       = CMP_W'(in_data.rem_x) >= sub;
        gey       = CMP_W'(in_data.rem_y) >= sub;
        lane_next = in_data;
        if (gex)
        begin
            lane_next.rem_x    = in_data.rem_x - sub[REM_W-1:0];
            lane_next.q_x[SHIFT] = 1'b1;
        end
        if (gey)
        begin
            lane_next.rem_y    = in_data.rem_y - sub[REM_W-1:0];
            lane_next.q_y[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (rdy)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy)
        begin
            lane_reg <= lane_next;
        end
    end

    assign up_ready  = rdy;
    assign out_valid = vld_reg;
    assign out_data  = lane_reg;

endmodule

FILE: hw/rtl/qcoc_final.sv
// ----------------------------------------------------------------------------
// qcoc_final
// Applies the quotient sign, adds the base point, saturates the center and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module qcoc_final
    import qcoc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  div_lane_t in_data,
    output logic      up_ready,
    output logic      out_valid,
    output quad_out_t out_data,
    input  logic      down_ready
);

    logic [1:0] vld_reg;
    logic [2:0] rdy;

    always_comb
    begin
        rdy[2] = down_ready;
        rdy[1] = !vld_reg[1] || rdy[2];
        rdy[0] = !vld_reg[0] || rdy[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    assign up_ready  = rdy[0];
    assign out_valid = vld_reg[1];

    logic [QBITS:0]         qfx, qfy;
    logic                   restx, resty;
    logic signed [QBITS+1:0] qsx_next, qsy_next;
    logic signed [QBITS+1:0] qsx1_reg, qsy1_reg;
    pts_t                   pts1_reg;
    logic                   par1_reg;

    always_comb
    begin
        qfx   = in_data.cap_x ? (QBITS+1)'(1) << QBITS : {1'b0, in_data.q_x};
        qfy   = in_data.cap_y ? (QBITS+1)'(1) << QBITS : {1'b0, in_data.q_y};
        restx = (in_data.rem_x != '0) && !in_data.cap_x;
        resty = (in_data.rem_y != '0) && !in_data.cap_y;
        qsx_next = in_data.nneg_x ? $signed(~{1'b0, qfx} + (QBITS+2)'(!restx))
                                  : $signed({1'b0, qfx});
        qsy_next = in_data.nneg_y ? $signed(~{1'b0, qfy} + (QBITS+2)'(!resty))
                                  : $signed({1'b0, qfy});
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            qsx1_reg <= qsx_next;
            qsy1_reg <= qsy_next;
            pts1_reg <= in_data.pts;
            par1_reg <= in_data.par;
        end
    end

    logic signed [QBITS+2:0] tx, ty;
    logic                    satx, saty;
    center_t                 cx, cy;
    quad_out_t               res_next;
    quad_out_t               res_reg;

    always_comb
    begin
        tx = $signed({{(QBITS-COORD_W+3){1'b0}}, pts1_reg.bl_x}) + (QBITS+3)'(qsx1_reg);
        ty = $signed({{(QBITS-COORD_W+3){1'b0}}, pts1_reg.bl_y}) + (QBITS+3)'(qsy1_reg);
        satx = 1'b0;
        saty = 1'b0;
        if (tx > (QBITS+3)'(CEN_MAX))
        begin
            cx   = CEN_MAX;
            satx = 1'b1;
        end
        else if (tx < (QBITS+3)'(CEN_MIN))
        begin
            cx   = CEN_MIN;
            satx = 1'b1;
        end
        else
        begin
            cx = tx[CEN_W-1:0];
        end
        if (ty > (QBITS+3)'(CEN_MAX))
        begin
            cy   = CEN_MAX;
            saty = 1'b1;
        end
        else if (ty < (QBITS+3)'(CEN_MIN))
        begin
            cy   = CEN_MIN;
            saty = 1'b1;
        end
        else
        begin
            cy = ty[CEN_W-1:0];
        end
        res_next.top_left_x     = pts1_reg.tl_x;
        res_next.top_left_y     = pts1_reg.tl_y;
        res_next.top_right_x    = pts1_reg.tr_x;
        res_next.top_right_y    = pts1_reg.tr_y;
        res_next.bottom_right_x = pts1_reg.br_x;
        res_next.bottom_right_y = pts1_reg.br_y;
        res_next.bottom_left_x  = pts1_reg.bl_x;
        res_next.bottom_left_y  = pts1_reg.bl_y;
        res_next.diagonals_parallel = par1_reg;
        if (par1_reg)
        begin
            res_next.center_x         = CEN_MAX;
            res_next.center_y         = CEN_MAX;
            res_next.center_saturated = 1'b0;
        end
        else
        begin
            res_next.center_x         = cx;
            res_next.center_y         = cy;
            res_next.center_saturated = satx || saty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            res_reg <= res_next;
        end
    end

    assign out_data = res_reg;

endmodule

FILE: hw/rtl/quad_corner_order_center.sv
// ----------------------------------------------------------------------------
// quad_corner_order_center
// Orders four quadrilateral corners and finds the diagonal intersection.
// ----------------------------------------------------------------------------
// The block takes one request of four corners every clock cycle while
// corners_stall is low, and returns one result per request, in order. A
// request passes through 5 ordering stages, 9 equation stages, the quotient
// pipeline, which resolves one of the 26 quotient bits per stage, and 2
// output stages. Each stage stalls only while it
// holds data that the next stage cannot take, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module quad_corner_order_center
    import qcoc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      corners_valid,
    output logic      corners_stall,
    input  quad_in_t  corners,
    output logic      result_valid,
    input  logic      result_stall,
    output quad_out_t result
);

    logic      ord_ready, ord_valid;
    pts_t      ord_data;
    logic      sol_ready, sol_valid;
    div_lane_t sol_data;
    logic      fin_ready;

    logic      dv  [QBITS+1];
    logic      dr  [QBITS+1];
    div_lane_t dl  [QBITS+1];

    qcoc_order #(
        .COORD_BITS (COORD_BITS)
    ) u_order (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (corners_valid),
        .in_data    (corners),
        .up_ready   (ord_ready),
        .out_valid  (ord_valid),
        .out_data   (ord_data),
        .down_ready (sol_ready)
    );

    qcoc_solve u_solve (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (ord_valid),
        .in_data    (ord_data),
        .up_ready   (sol_ready),
        .out_valid  (sol_valid),
        .out_data   (sol_data),
        .down_ready (dr[0])
    );

    assign dv[0] = sol_valid;
    assign dl[0] = sol_data;

    for (genvar j = 0; j < QBITS; j++)
    begin : g_div
        qcoc_div_stage #(
            .SHIFT (QBITS - 1 - j)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (dv[j]),
            .in_data    (dl[j]),
            .up_ready   (dr[j]),
            .out_valid  (dv[j+1]),
            .out_data   (dl[j+1]),
            .down_ready (dr[j+1])
        );
    end

    assign dr[QBITS] = fin_ready;

    qcoc_final u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (dv[QBITS]),
        .in_data    (dl[QBITS]),
        .up_ready   (fin_ready),
        .out_valid  (result_valid),
        .out_data   (result),
        .down_ready (!result_stall)
    );

    assign corners_stall = !ord_ready;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the quadrilateral corner ordering block. A table of
// directed requests is followed by random requests of several shapes (full
// range, clustered, near-collinear, repeated and edge corners). Each accepted
// request is predicted by a local model of the ordering and of the rounded,
// saturated diagonal intersection, and results are compared in order.
// ----------------------------------------------------------------------------
module tb_top;
    import qcoc_pkg::*;

    localparam int  N_RANDOM    = 1440;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN       = 120;

    logic      clk;
    logic      rst_n;
    logic      corners_valid;
    logic      corners_stall;
    quad_in_t  corners;
    logic      result_valid;
    logic      result_stall;
    quad_out_t result;

    quad_out_t pending_result;
    quad_out_t expected_results[$];
    quad_in_t  stim_table[$];
    bit        typed[$];
    quad_out_t typed_result[$];
    int        mismatches;
    int        cycles;
    bit        quiet;

    quad_corner_order_center dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .corners_valid (corners_valid),
        .corners_stall (corners_stall),
        .corners       (corners),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic longint center_axis(longint base, longint dir, longint nc,
                                           longint dc, inout bit sat);
        longint unsigned p;
        longint unsigned m;
        longint unsigned den;
        longint unsigned qf;
        bit              neg;
        bit              numneg;
        bit              rest;
        longint          q;
        longint          t;
        p = 2 * longint'(dir < 0 ? -dir : dir) * longint'(nc < 0 ? -nc : nc);
        neg = ((dir < 0) != (nc < 0)) && dir != 0 && nc != 0;
        den = 2 * dc;
        numneg = 1'b0;
        if (!neg)
        begin
            m = p + dc;
        end
        else if (p > dc)
        begin
            m = p - dc;
            numneg = 1'b1;
        end
        else
        begin
            m = dc - p;
        end
        if (m >= (den << QBITS))
        begin
            qf = longint'(1) << QBITS;
            rest = 1'b0;
        end
        else
        begin
            qf = m / den;
            rest = (m % den) != 0;
        end
        q = numneg ? -(longint'(qf) + longint'(rest)) : longint'(qf);
        t = base + q;
        if (t > longint'(CEN_MAX))
        begin
            sat = 1'b1;
            return longint'(CEN_MAX);
        end
        if (t < longint'(CEN_MIN))
        begin
            sat = 1'b1;
            return longint'(CEN_MIN);
        end
        return t;
    endfunction

    function automatic quad_out_t order_and_center(quad_in_t q);
        longint    px[4];
        longint    py[4];
        longint    s[4];
        int        tl;
        int        br;
        int        cnt;
        int        oth[2];
        int        tr;
        int        bl;
        longint    z;
        longint    fx;
        longint    fy;
        longint    ex;
        longint    ey;
        longint    dc;
        longint    nc;
        longint    cx;
        longint    cy;
        bit        sat;
        quad_out_t r;
        px[0] = q.corner0_x; py[0] = q.corner0_y;
        px[1] = q.corner1_x; py[1] = q.corner1_y;
        px[2] = q.corner2_x; py[2] = q.corner2_y;
        px[3] = q.corner3_x; py[3] = q.corner3_y;
        tl = 0;
        br = 0;
        cnt = 0;
        oth[0] = 0;
        oth[1] = 0;
        sat = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            s[i] = px[i] + py[i];
        end
        for (int i = 1; i < 4; i++)
        begin
            if (s[i] < s[tl])
                tl = i;
            if (s[i] > s[br])
                br = i;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (i != tl && i != br && cnt < 2)
            begin
                oth[cnt] = i;
                cnt++;
            end
        end
        z = (px[oth[1]] - px[tl]) * (py[oth[0]] - py[tl])
          - (py[oth[1]] - py[tl]) * (px[oth[0]] - px[tl]);
        if (z < 0)
        begin
            tr = oth[0];
            bl = oth[1];
        end
        else
        begin
            tr = oth[1];
            bl = oth[0];
        end
        fx = px[tr] - px[bl];
        fy = py[tr] - py[bl];
        ex = px[br] - px[tl];
        ey = py[br] - py[tl];
        dc = fx * ey - fy * ex;
        nc = (px[tl] - px[bl]) * ey - (py[tl] - py[bl]) * ex;
        r.diagonals_parallel = (dc == 0);
        if (dc == 0)
        begin
            cx = CEN_MAX;
            cy = CEN_MAX;
        end
        else
        begin
            if (dc < 0)
            begin
                dc = -dc;
                nc = -nc;
            end
            cx = center_axis(px[bl], fx, nc, dc, sat);
            cy = center_axis(py[bl], fy, nc, dc, sat);
        end
        r.top_left_x     = px[tl][15:0];
        r.top_left_y     = py[tl][15:0];
        r.top_right_x    = px[tr][15:0];
        r.top_right_y    = py[tr][15:0];
        r.bottom_right_x = px[br][15:0];
        r.bottom_right_y = py[br][15:0];
        r.bottom_left_x  = px[bl][15:0];
        r.bottom_left_y  = py[bl][15:0];
        r.center_x       = cx[CEN_W-1:0];
        r.center_y       = cy[CEN_W-1:0];
        r.center_saturated = sat;
        return r;
    endfunction

    function automatic coord_t near(coord_t c, int spread);
        int v;
        v = int'(c) + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return coord_t'(v);
    endfunction

    function automatic quad_in_t random_quad();
        coord_t   c[8];
        coord_t   bx;
        coord_t   by;
        int       shape;
        quad_in_t q;
        shape = $urandom_range(0, 9);
        bx = coord_t'($urandom);
        by = coord_t'($urandom);
        for (int i = 0; i < 4; i++)
        begin
            case (shape)
                0, 1, 2, 3:
                begin
                    c[2*i]   = coord_t'($urandom);
                    c[2*i+1] = coord_t'($urandom);
                end
                4, 5:
                begin
                    c[2*i]   = near(bx, 8);
                    c[2*i+1] = near(by, 8);
                end
                6, 7:
                begin
                    c[2*i]   = coord_t'($urandom);
                    c[2*i+1] = near(c[2*i], $urandom_range(0, 3));
                end
                8:
                begin
                    c[2*i]   = $urandom_range(0, 1) ? bx : coord_t'($urandom);
                    c[2*i+1] = $urandom_range(0, 1) ? by : coord_t'($urandom);
                end
                default:
                begin
                    c[2*i]   = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
                    c[2*i+1] = $urandom_range(0, 1) ? 16'h0000 : coord_t'($urandom);
                end
            endcase
        end
        q = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]};
        return q;
    endfunction

    task automatic add_row(quad_in_t stim, bit is_typed, quad_out_t want);
        stim_table   = {stim_table, stim};
        typed        = {typed, is_typed};
        typed_result = {typed_result, want};
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quad_corner_order_center regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        quad_out_t want;
        if (rst_n && corners_valid && !corners_stall)
            expected_results = {expected_results, pending_result};
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report("unexpected result", 1, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.top_left_x != want.top_left_x)
                    report("top_left_x", result.top_left_x, want.top_left_x);
                if (result.top_left_y != want.top_left_y)
                    report("top_left_y", result.top_left_y, want.top_left_y);
                if (result.top_right_x != want.top_right_x)
                    report("top_right_x", result.top_right_x, want.top_right_x);
                if (result.top_right_y != want.top_right_y)
                    report("top_right_y", result.top_right_y, want.top_right_y);
                if (result.bottom_right_x != want.bottom_right_x)
                    report("bottom_right_x", result.bottom_right_x, want.bottom_right_x);
                if (result.bottom_right_y != want.bottom_right_y)
                    report("bottom_right_y", result.bottom_right_y, want.bottom_right_y);
                if (result.bottom_left_x != want.bottom_left_x)
                    report("bottom_left_x", result.bottom_left_x, want.bottom_left_x);
                if (result.bottom_left_y != want.bottom_left_y)
                    report("bottom_left_y", result.bottom_left_y, want.bottom_left_y);
                if (result.center_x != want.center_x)
                    report("center_x", result.center_x, want.center_x);
                if (result.center_y != want.center_y)
                    report("center_y", result.center_y, want.center_y);
                if (result.diagonals_parallel != want.diagonals_parallel)
                    report("diagonals_parallel", result.diagonals_parallel,
                           want.diagonals_parallel);
                if (result.center_saturated != want.center_saturated)
                    report("center_saturated", result.center_saturated,
                           want.center_saturated);
            end
        end
    end

    always @(negedge clk)
    begin
        result_stall <= !quiet && ($urandom_range(0, 99) < 13);
    end

    initial
    begin
        quad_in_t  q;
        int        total;
        mismatches = 0;
        cycles = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        corners_valid = 1'b0;
        corners = '0;
        result_stall = 1'b0;
        pending_result = '0;

        // Degenerate quads with every point equal give parallel diagonals.
        add_row('0, 1'b1, {{8{16'h0000}}, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0});
        add_row('1, 1'b1, {{8{16'hFFFF}}, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0});
        add_row({16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
                 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, '0);
        add_row({16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,
                 16'h0000, 16'h0000, 16'hFFFF, 16'h0000}, 1'b0, '0);
        add_row({16'h0000, 16'h0040, 16'h0040, 16'h0000,
                 16'h0020, 16'h0020, 16'h0010, 16'h0030}, 1'b0, '0);
        add_row({16'h0010, 16'h0010, 16'h0100, 16'h0020,
                 16'h0100, 16'h0100, 16'h0020, 16'h0110}, 1'b0, '0);
        add_row({16'h0000, 16'h0000, 16'h0001, 16'h0000,
                 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF}, 1'b0, '0);
        add_row({16'h0000, 16'h0000, 16'h0003, 16'h0000,
                 16'h0003, 16'h0003, 16'h0000, 16'h0001}, 1'b0, '0);
        add_row({16'h1234, 16'h0000, 16'h0000, 16'h1234,
                 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0);
        add_row({16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                 16'h8000, 16'h8000, 16'h7FFF, 16'h8001}, 1'b0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        total = stim_table.size() + N_RANDOM;
        for (int n = 0; n < total; n++)
        begin
            quiet = (n >= 500 && n < 800);
            if (n < stim_table.size())
            begin
                q = stim_table[n];
                pending_result = typed[n] ? typed_result[n] : order_and_center(q);
            end
            else
            begin
                q = random_quad();
                pending_result = order_and_center(q);
            end
            while (!quiet && $urandom_range(0, 99) < 13)
            begin
                corners_valid <= 1'b0;
                @(negedge clk);
            end
            corners_valid <= 1'b1;
            corners <= q;
            @(posedge clk);
            while (corners_stall)
                @(posedge clk);
            @(negedge clk);
        end
        corners_valid <= 1'b0;
        quiet = 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("quad_corner_order_center regression: pass");
        else
            $display("quad_corner_order_center regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/qcoc_pkg.sv
hw/rtl/qcoc_order.sv
hw/rtl/qcoc_solve.sv
hw/rtl/qcoc_div_stage.sv
hw/rtl/qcoc_final.sv
hw/rtl/quad_corner_order_center.sv
tb/tb_top.sv
